[src/bavg_pkg.sv]
`default_nettype none
package bavg_pkg;

	localparam int GLEN_W = 9;
	localparam logic [GLEN_W-1:0] GLEN_RESET = 9'd4;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;

endpackage
`default_nettype wire

[src/bavg_in_if.sv]
`default_nettype none
interface bavg_in_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample;
	logic                           end_of_packet;

	modport source (output valid, sample, end_of_packet, input ready);
	modport sink (input valid, sample, end_of_packet, output ready);
endinterface
`default_nettype wire

[src/bavg_out_if.sv]
`default_nettype none
interface bavg_out_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] average;
	logic                           last;

	modport source (output valid, average, last, input ready);
	modport sink (input valid, average, last, output ready);
endinterface
`default_nettype wire

[src/bavg_cfg_if.sv]
`default_nettype none
interface bavg_cfg_if
	import bavg_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [GLEN_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

[src/bavg_front.sv]
`default_nettype none
module bavg_front
	import bavg_pkg::*;
#(
	parameter int MAX_GROUP    = 256,
	parameter int SAMPLE_WIDTH = 16,
	parameter int SUM_W        = 24,
	parameter int CNT_W        = 9
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	bavg_in_if.sink                      samples,
	bavg_cfg_if.sink                     cfg,
	output logic                         push_valid,
	input  wire logic                    push_ready,
	output logic [SUM_W+CNT_W:0]         push_data
);

	logic [GLEN_W-1:0] group_len_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SUM_W-1:0]  sum_new;
	logic [CNT_W-1:0]  cnt_new;
	logic [31:0]       glen_ext;
	logic [31:0]       eff_len;
	logic              close;
	logic              accept;

	assign cfg.ready     = 1'b1;
	assign samples.ready = push_ready;
	assign accept        = samples.valid && push_ready;

	assign glen_ext = 32'(group_len_q);
	assign eff_len  = (glen_ext == 32'd0) ? 32'd1 :
	                  (glen_ext > 32'(MAX_GROUP)) ? 32'(MAX_GROUP) : glen_ext;

	assign sum_new = sum_q + {{(SUM_W-SAMPLE_WIDTH){samples.sample[SAMPLE_WIDTH-1]}},
	                          samples.sample};
	assign cnt_new = cnt_q + CNT_W'(1);
	assign close   = samples.end_of_packet || (32'(cnt_new) >= eff_len);

	assign push_valid = accept && close;
	assign push_data  = {sum_new, cnt_new, samples.end_of_packet};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_len_q <= GLEN_RESET;
			sum_q       <= '0;
			cnt_q       <= '0;
		end else begin
			if (cfg.valid) begin
				group_len_q <= cfg.data;
			end
			if (accept) begin
				if (close) begin
					sum_q <= '0;
					cnt_q <= '0;
				end else begin
					sum_q <= sum_new;
					cnt_q <= cnt_new;
				end
			end
		end
	end

endmodule
`default_nettype wire

[src/bavg_queue.sv]
`default_nettype none
module bavg_queue #(
	parameter int WIDTH = 34
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  pop_valid,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      pop_data
);

	logic [WIDTH-1:0] entry_q [2];
	logic             wptr_q;
	logic             rptr_q;
	logic [1:0]       fill_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid  = (fill_q != 2'd0);
	assign pop_data   = entry_q[rptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (do_push) begin
				wptr_q <= ~wptr_q;
			end
			if (do_pop) begin
				rptr_q <= ~rptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule
`default_nettype wire

[src/bavg_div.sv]
`default_nettype none
module bavg_div
	import bavg_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 16,
	parameter int SUM_W        = 24,
	parameter int CNT_W        = 9
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 pop_valid,
	output logic                      pop,
	input  wire logic [SUM_W+CNT_W:0] pop_data,
	bavg_out_if.source                averages
);

	localparam int STEP_W = $clog2(SUM_W + 1);

	logic [1:0]              state_q;
	logic [STEP_W-1:0]       step_q;
	logic [SUM_W-1:0]        quo_q;
	logic [CNT_W-1:0]        rem_q;
	logic [CNT_W-1:0]        div_q;
	logic                    neg_q;
	logic                    last_q;
	logic                    out_valid_q;
	logic [SAMPLE_WIDTH-1:0] out_avg_q;
	logic                    out_last_q;

	logic [SUM_W-1:0] in_sum;
	logic [CNT_W-1:0] in_cnt;
	logic             in_last;
	logic [SUM_W-1:0] in_mag;
	logic [CNT_W:0]   trial;
	logic [CNT_W:0]   diff;
	logic             ge;
	logic             done;
	logic             out_free;
	logic [SUM_W-1:0] signed_quo;

	assign {in_sum, in_cnt, in_last} = pop_data;
	assign in_mag = in_sum[SUM_W-1] ? (~in_sum + SUM_W'(1)) : in_sum;

	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = (trial >= {1'b0, div_q});

	assign done       = (step_q == STEP_W'(SUM_W));
	assign out_free   = !out_valid_q || averages.ready;
	assign signed_quo = neg_q ? (~quo_q + SUM_W'(1)) : quo_q;

	assign pop              = (state_q == ST_IDLE) && pop_valid;
	assign averages.valid   = out_valid_q;
	assign averages.average = out_avg_q;
	assign averages.last    = out_last_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			quo_q  <= in_mag;
			rem_q  <= '0;
			div_q  <= in_cnt;
			neg_q  <= in_sum[SUM_W-1];
			last_q <= in_last;
		end else if ((state_q == ST_DIV) && !done) begin
			quo_q <= {quo_q[SUM_W-2:0], ge};
			rem_q <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
		end
		if ((state_q == ST_DIV) && done && out_free) begin
			out_avg_q  <= signed_quo[SAMPLE_WIDTH-1:0];
			out_last_q <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DIV) && done && out_free) begin
				out_valid_q <= 1'b1;
			end else if (averages.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						state_q <= ST_DIV;
						step_q  <= '0;
					end
				end
				ST_DIV: begin
					if (!done) begin
						step_q <= step_q + STEP_W'(1);
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[src/block_average_decimator_unit.sv]
`default_nettype none
// Block averager: sums signed samples into groups of group_len (0 acts as 1, values above
// MAX_GROUP act as MAX_GROUP), closing a group early at end of packet, and returns the group
// mean truncated toward zero with the packet-end flag. The front end takes one sample per
// cycle while its two-entry group queue has room; each closed group then occupies the
// restoring divider, one quotient bit per cycle, until its result can enter the output
// register, and the divider takes no new group before then, so short groups can fill the
// queue and hold the front end back. group_len is written through cfg and resets to 4.
module block_average_decimator_unit
	import bavg_pkg::*;
#(
	parameter int MAX_GROUP    = 256,
	parameter int SAMPLE_WIDTH = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bavg_in_if.sink    samples,
	bavg_out_if.source averages,
	bavg_cfg_if.sink   cfg
);

	localparam int CNT_W = $clog2(MAX_GROUP + 1);
	localparam int SUM_W = SAMPLE_WIDTH + $clog2(MAX_GROUP);
	localparam int QW    = SUM_W + CNT_W + 1;

	logic          push_valid;
	logic          push_ready;
	logic [QW-1:0] push_data;
	logic          pop_valid;
	logic          pop;
	logic [QW-1:0] pop_data;

	bavg_front #(
		.MAX_GROUP    (MAX_GROUP),
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.SUM_W        (SUM_W),
		.CNT_W        (CNT_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.cfg        (cfg),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	bavg_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_data   (pop_data)
	);

	bavg_div #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.SUM_W        (SUM_W),
		.CNT_W        (CNT_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_data  (pop_data),
		.averages  (averages)
	);

endmodule
`default_nettype wire

[src/bavg_chk.sv]
`default_nettype none
module bavg_chk #(
	parameter int SAMPLE_WIDTH = 16
) (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    out_valid,
	input wire logic                    out_ready,
	input wire logic [SAMPLE_WIDTH-1:0] out_average,
	input wire logic                    out_last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result request dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_average) && $stable(out_last))
		else $error("result payload changed while stalled");

	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result request present out of reset");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(arst_n, 1) && $past(arst_n, 2))
		else $error("result appeared too soon after reset");

endmodule

bind block_average_decimator_unit bavg_chk #(
	.SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_bavg_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (averages.valid),
	.out_ready   (averages.ready),
	.out_average (averages.average),
	.out_last    (averages.last)
);
`default_nettype wire

[verif/block_average_decimator_unit_tb.sv]
module block_average_decimator_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bavg_pkg::*;

	localparam int SW           = 16;
	localparam int MAX_GROUP    = 256;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic signed [SW-1:0] average;
		logic                 last;
	} avg_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	bavg_in_if  #(.SAMPLE_WIDTH(SW)) samples_if ();
	bavg_out_if #(.SAMPLE_WIDTH(SW)) averages_if ();
	bavg_cfg_if                      cfg_if ();

	block_average_decimator_unit #(
		.MAX_GROUP   (MAX_GROUP),
		.SAMPLE_WIDTH(SW)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.averages(averages_if),
		.cfg     (cfg_if)
	);

	logic [GLEN_W-1:0] group_len_q = GLEN_RESET;
	longint            group_sum   = 0;
	int                group_count = 0;
	avg_result_t       pending_avgs[$];
	int                n_mismatch  = 0;
	int                burst_left  = 0;
	int                cycle_cnt   = 0;

	always #4 clk = ~clk;

	function automatic int effective_group_len();
		int n;
		n = group_len_q;
		if (n == 0) begin
			n = 1;
		end
		if (n > MAX_GROUP) begin
			n = MAX_GROUP;
		end
		return n;
	endfunction

	function automatic void predict_average(input logic signed [SW-1:0] s, input logic eop);
		avg_result_t r;
		group_sum += s;
		group_count++;
		if (group_count >= effective_group_len() || eop) begin
			r.average = SW'(group_sum / longint'(group_count));
			r.last    = eop;
			pending_avgs.push_back(r);
			group_sum   = 0;
			group_count = 0;
		end
	endfunction

	function automatic logic signed [SW-1:0] pick_sample(input int mode);
		case (mode)
			1: return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
			2: return 16'sh8000;
			3: return SW'(int'($urandom_range(0, 15)) - 8);
			4: return 16'sh7FFF;
			default: return SW'($urandom);
		endcase
	endfunction

	task automatic send_sample(input logic signed [SW-1:0] s, input logic eop);
		if (burst_left == 0) begin
			samples_if.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
		end
		burst_left--;
		samples_if.valid         <= 1'b1;
		samples_if.sample        <= s;
		samples_if.end_of_packet <= eop;
		@(posedge clk);
		while (!samples_if.ready) @(posedge clk);
		predict_average(s, eop);
		@(negedge clk);
	endtask

	// only while idle: no request outstanding and the divider drained
	task automatic write_group_len(input logic [GLEN_W-1:0] v);
		samples_if.valid <= 1'b0;
		while (pending_avgs.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= v;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		group_len_q = v;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic test_default_len_directed();
		repeat (4) send_sample(16'sh7FFF, 1'b0);
		repeat (4) send_sample(16'sh8000, 1'b0);
		// -0.75 truncates to zero
		send_sample(-16'sd3, 1'b0);
		repeat (3) send_sample(16'sd0, 1'b0);
		repeat (3) send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sh8000, 1'b1);
		send_sample(16'sd5, 1'b1);
		send_sample(-16'sd7, 1'b0);
		send_sample(-16'sd7, 1'b0);
		send_sample(-16'sd6, 1'b1);
	endtask

	task automatic test_len_change_mid_group();
		int i;
		write_group_len(9'd8);
		for (i = 0; i < 5; i++) begin
			send_sample(pick_sample(0), 1'b0);
		end
		write_group_len(9'd3);
		send_sample(pick_sample(0), 1'b0);
		send_sample(pick_sample(0), 1'b0);
		send_sample(pick_sample(0), 1'b1);
	endtask

	task automatic test_full_group_extremes();
		int i;
		write_group_len(9'd256);
		for (i = 0; i < MAX_GROUP; i++) begin
			send_sample(16'sh8000, 1'b0);
		end
		for (i = 0; i < MAX_GROUP; i++) begin
			send_sample(16'sh7FFF, i == MAX_GROUP - 1);
		end
	endtask

	task automatic test_random_packets(input logic [GLEN_W-1:0] len, input int n_items);
		int eff, plen, mode, i, sent;
		write_group_len(len);
		eff  = effective_group_len();
		sent = 0;
		while (sent < n_items) begin
			case ($urandom_range(0, 3))
				0:       plen = $urandom_range(1, 3);
				1, 2:    plen = $urandom_range(1, 2 * eff + 3);
				default: plen = $urandom_range(eff, 3 * eff);
			endcase
			mode = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 4);
			for (i = 0; i < plen && sent < n_items; i++) begin
				send_sample(pick_sample(mode), i == plen - 1);
				sent++;
			end
		end
	endtask

	always @(negedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		case ((cycle_cnt >> 8) % 4)
			0: averages_if.ready <= 1'b1;
			1: averages_if.ready <= ($urandom_range(0, 3) != 0);
			2: averages_if.ready <= ((cycle_cnt % 16) < 5);
			default: averages_if.ready <= ($urandom_range(0, 4) == 0);
		endcase
	end

	always @(posedge clk) begin
		avg_result_t want;
		if (arst_n && averages_if.valid && averages_if.ready) begin
			if (pending_avgs.size() == 0) begin
				if (n_mismatch < 10) begin
					$display("unexpected average %0d last %0b", averages_if.average,
						averages_if.last);
				end
				n_mismatch++;
			end else begin
				want = pending_avgs.pop_front();
				if (averages_if.average !== want.average || averages_if.last !== want.last) begin
					if (n_mismatch < 10) begin
						$display("average mismatch: exp %0d/%0b got %0d/%0b", want.average,
							want.last, averages_if.average, averages_if.last);
					end
					n_mismatch++;
				end
			end
		end
	end

	initial begin
		samples_if.valid         = 1'b0;
		samples_if.sample        = '0;
		samples_if.end_of_packet = 1'b0;
		cfg_if.valid             = 1'b0;
		cfg_if.data              = '0;
		averages_if.ready        = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_default_len_directed();
		test_len_change_mid_group();
		test_full_group_extremes();
		test_random_packets(9'd0, 100);
		test_random_packets(9'd1, 80);
		test_random_packets(9'd2, 100);
		test_random_packets(9'd3, 100);
		test_random_packets(9'd4, 100);
		test_random_packets(9'd26, 120);
		test_random_packets(9'd27, 120);
		test_random_packets(9'd511, 200);
		test_random_packets(9'd257, 60);
		test_random_packets(GLEN_W'($urandom_range(5, 80)), 100);

		samples_if.valid <= 1'b0;
		while (pending_avgs.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (n_mismatch == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

[files.f]
src/bavg_pkg.sv
src/bavg_in_if.sv
src/bavg_out_if.sv
src/bavg_cfg_if.sv
src/bavg_front.sv
src/bavg_queue.sv
src/bavg_div.sv
src/block_average_decimator_unit.sv
src/bavg_chk.sv
verif/block_average_decimator_unit_tb.sv
